@@ rtl/dtg_pkg.sv @@
// types and constants shared by the grouped decimal text block
package dtg_pkg;

	localparam int VALUE_W = 31;
	localparam int CHAR_W  = 8;
	localparam int DIGIT_W = 4;
	localparam int CNT_W   = $clog2(VALUE_W);

	localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CHAR_COMMA = 8'h2C;

	typedef logic [VALUE_W-1:0] value_t;
	typedef logic [CHAR_W-1:0]  char_t;
	typedef logic [DIGIT_W-1:0] digit_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_SKIP,
		ST_EMIT
	} dtg_state_t;

	typedef struct packed {
		logic clear;
		logic dabble;
		logic shift;
	} dtg_row_ctrl_t;

endpackage

@@ rtl/dtg_in_if.sv @@
// input channel: one integer per transfer
interface dtg_in_if
	import dtg_pkg::*;
();
	logic   valid;
	logic   ready;
	value_t value;

	modport source(output valid, output value, input ready);
	modport sink(input valid, input value, output ready);
endinterface

@@ rtl/dtg_out_if.sv @@
// output channel: one ascii character per transfer
interface dtg_out_if
	import dtg_pkg::*;
();
	logic  valid;
	logic  ready;
	char_t char_byte;
	logic  last_char;

	modport source(output valid, output char_byte, output last_char, input ready);
	modport sink(input valid, input char_byte, input last_char, output ready);
endinterface

@@ rtl/decimal_text_with_digit_grouping_top.sv @@
// grouped decimal text: integer in, ascii digits and commas out
//
//  channel  dir  payload                  meaning
//  num      in   value[30:0]              integer to convert
//  txt      out  char_byte[7:0], last_char digit or comma, last mark
//
// an item is taken in the idle state, then converted one value bit per cycle
// through the cell row, then leading zero digits are dropped (up to
// MAX_DIGITS-1), then characters go out one per cycle while txt does not stall
// num is taken only while idle; the output register lets the last character
// wait for txt.ready while the next number is already accepted
// txt stalls hold the character register and pause the cell row
// arst_n clears the control state; the cells are cleared at each transfer
module decimal_text_with_digit_grouping_top
	import dtg_pkg::*;
#(
	parameter int MAX_DIGITS = 10
) (
	input logic      clk,
	input logic      arst_n,
	dtg_in_if.sink   num,
	dtg_out_if.source txt
);

	localparam int REM_W = $clog2(MAX_DIGITS + 1);
	localparam logic [1:0] GRP_INIT = 2'((MAX_DIGITS - 1) % 3);

	dtg_state_t     state_q, state_d;
	dtg_row_ctrl_t  row_ctrl;
	value_t         value_q;
	logic [CNT_W-1:0] cnt_q;
	logic           ovf_q;
	logic [REM_W-1:0] rem_q;
	logic [1:0]     grp_q;
	logic           comma_q;
	char_t          char_q;
	logic           last_q;
	logic           out_valid_q;

	logic   carry_top;
	digit_t digit_top;
	logic   accept;
	logic   slot_free;
	logic   skip_cond;
	logic   load_out;
	logic   rem_one;

	dtg_cell_row #(
		.MAX_DIGITS (MAX_DIGITS)
	) u_row (
		.clk       (clk),
		.ctrl      (row_ctrl),
		.bit_in    (value_q[VALUE_W-1]),
		.carry_top (carry_top),
		.digit_top (digit_top)
	);

	assign accept    = num.valid && num.ready;
	assign slot_free = !out_valid_q || txt.ready;
	assign rem_one   = (rem_q == REM_W'(1));
	assign skip_cond = (digit_top == '0) && !rem_one && !ovf_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (num.valid) begin
					state_d = ST_CONV;
				end
			end
			ST_CONV: begin
				if (cnt_q == '0) begin
					state_d = ST_SKIP;
				end
			end
			ST_SKIP: begin
				if (!skip_cond) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (slot_free && !comma_q && rem_one) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		num.ready       = 1'b0;
		row_ctrl.clear  = 1'b0;
		row_ctrl.dabble = 1'b0;
		row_ctrl.shift  = 1'b0;
		load_out        = 1'b0;
		case (state_q)
			ST_IDLE: begin
				num.ready      = 1'b1;
				row_ctrl.clear = num.valid;
			end
			ST_CONV: begin
				row_ctrl.dabble = 1'b1;
			end
			ST_SKIP: begin
				row_ctrl.shift = skip_cond;
			end
			ST_EMIT: begin
				load_out       = slot_free;
				row_ctrl.shift = slot_free && !comma_q;
			end
			default: begin
				num.ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			ovf_q   <= 1'b0;
			rem_q   <= '0;
			grp_q   <= '0;
			comma_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				cnt_q   <= CNT_W'(VALUE_W - 1);
				ovf_q   <= 1'b0;
				rem_q   <= REM_W'(MAX_DIGITS);
				grp_q   <= GRP_INIT;
				comma_q <= 1'b0;
			end else begin
				if (row_ctrl.dabble) begin
					cnt_q <= cnt_q - CNT_W'(1);
					ovf_q <= ovf_q | carry_top;
				end
				if (row_ctrl.shift) begin
					rem_q <= rem_q - REM_W'(1);
					grp_q <= (grp_q == 2'd0) ? 2'd2 : grp_q - 2'd1;
				end
				if (load_out) begin
					// a comma follows a digit whose place is a nonzero multiple of three
					comma_q <= !comma_q && !rem_one && (grp_q == 2'd0);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			value_q <= num.value;
		end else if (row_ctrl.dabble) begin
			value_q <= {value_q[VALUE_W-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (txt.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			if (comma_q) begin
				char_q <= CHAR_COMMA;
				last_q <= 1'b0;
			end else begin
				char_q <= CHAR_ZERO + {{(CHAR_W - DIGIT_W){1'b0}}, digit_top};
				last_q <= rem_one;
			end
		end
	end

	assign txt.valid     = out_valid_q;
	assign txt.char_byte = char_q;
	assign txt.last_char = last_q;

endmodule

@@ rtl/dtg_cell.sv @@
// one bcd digit cell: shift-add-3 step or digit shift toward the top
module dtg_cell
	import dtg_pkg::*;
(
	input  logic          clk,
	input  dtg_row_ctrl_t ctrl,
	input  logic          bit_in,
	input  digit_t        digit_in,
	output logic          carry_out,
	output digit_t        digit
);

	digit_t digit_q;
	digit_t adj;

	always_comb begin
		adj = (digit_q >= digit_t'(5)) ? digit_q + digit_t'(3) : digit_q;
	end

	assign carry_out = adj[DIGIT_W-1];
	assign digit     = digit_q;

	always_ff @(posedge clk) begin
		if (ctrl.clear) begin
			digit_q <= '0;
		end else if (ctrl.dabble) begin
			digit_q <= {adj[DIGIT_W-2:0], bit_in};
		end else if (ctrl.shift) begin
			digit_q <= digit_in;
		end
	end

endmodule

@@ rtl/dtg_cell_row.sv @@
// row of bcd digit cells, least significant digit at cell 0
module dtg_cell_row
	import dtg_pkg::*;
#(
	parameter int MAX_DIGITS = 10
) (
	input  logic          clk,
	input  dtg_row_ctrl_t ctrl,
	input  logic          bit_in,
	output logic          carry_top,
	output digit_t        digit_top
);

	logic   carry [MAX_DIGITS];
	digit_t dig   [MAX_DIGITS];

	for (genvar k = 0; k < MAX_DIGITS; k++) begin : g_cell
		logic   b_in;
		digit_t d_in;

		if (k == 0) begin : g_first
			assign b_in = bit_in;
			assign d_in = '0;
		end else begin : g_rest
			assign b_in = carry[k-1];
			assign d_in = dig[k-1];
		end

		dtg_cell u_cell (
			.clk       (clk),
			.ctrl      (ctrl),
			.bit_in    (b_in),
			.digit_in  (d_in),
			.carry_out (carry[k]),
			.digit     (dig[k])
		);
	end

	assign carry_top = carry[MAX_DIGITS-1];
	assign digit_top = dig[MAX_DIGITS-1];

endmodule

@@ tb/sv/decimal_text_with_digit_grouping_top_tb.sv @@
`timescale 1ns / 100ps
// testbench for the grouped decimal text block: predicted characters checked per transfer
module decimal_text_with_digit_grouping_top_tb;
	import dtg_pkg::*;

	localparam int MAX_DIGITS    = 10;
	localparam int STALL_LIMIT   = 5000;
	localparam int SETTLE_CYCLES = 60;

	typedef struct {
		char_t ch;
		logic  is_last;
	} text_char_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	int src_idle_pct  = 0;
	int snk_stall_pct = 0;
	int fail_cnt      = 0;
	int quiet_cycles  = 0;

	text_char_t pending_chars[$];

	dtg_in_if  num_if();
	dtg_out_if txt_if();

	decimal_text_with_digit_grouping_top #(
		.MAX_DIGITS(MAX_DIGITS)
	) u_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.num   (num_if),
		.txt   (txt_if)
	);

	always #4 clk = ~clk;

	function automatic int unsigned pow10(int unsigned k);
		int unsigned p;
		p = 1;
		repeat (k) p = p * 10;
		return p;
	endfunction

	// digits most significant first, comma between groups of three
	function automatic void predict_text(value_t v);
		digit_t      digs[MAX_DIGITS];
		int unsigned rem;
		int          nd;
		int          i;
		text_char_t  c;
		rem = v;
		nd  = 0;
		do begin
			digs[nd] = digit_t'(rem % 10);
			rem = rem / 10;
			nd++;
		end while (rem != 0 && nd < MAX_DIGITS);
		for (i = nd - 1; i >= 0; i--) begin
			c.ch      = char_t'(CHAR_ZERO + digs[i]);
			c.is_last = (i == 0);
			pending_chars.push_back(c);
			if (i > 0 && i % 3 == 0) begin
				c.ch      = CHAR_COMMA;
				c.is_last = 1'b0;
				pending_chars.push_back(c);
			end
		end
	endfunction

	function automatic value_t random_value();
		int unsigned digits;
		int unsigned lo;
		int unsigned hi;
		int unsigned k;
		case ($urandom_range(0, 3))
			0: return value_t'($urandom);
			1: begin
				digits = $urandom_range(1, 10);
				lo = (digits == 1) ? 0 : pow10(digits - 1);
				hi = (digits == 10) ? 32'h7FFF_FFFF : pow10(digits) - 1;
				return value_t'($urandom_range(hi, lo));
			end
			2: begin
				k = $urandom_range(0, 9);
				return $urandom_range(0, 1) ? value_t'(pow10(k)) : value_t'(pow10(k) - 1);
			end
			default: return value_t'($urandom_range(0, 9999));
		endcase
	endfunction

	task automatic send_value(value_t v);
		@(negedge clk);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			num_if.valid <= 1'b0;
			num_if.value <= value_t'($urandom);
			@(negedge clk);
		end
		num_if.valid <= 1'b1;
		num_if.value <= v;
		do @(posedge clk); while (!num_if.ready);
		predict_text(v);
	endtask

	task automatic stop_sending();
		@(negedge clk);
		num_if.valid <= 1'b0;
	endtask

	task automatic wait_text_drained();
		while (pending_chars.size() != 0) @(posedge clk);
	endtask

	task automatic set_idling(int src_pct, int snk_pct);
		src_idle_pct  = src_pct;
		snk_stall_pct = snk_pct;
	endtask

	task automatic test_digit_boundaries();
		value_t list[] = '{
			31'd0, 31'd1, 31'd9, 31'd10, 31'd99, 31'd100, 31'd999, 31'd1000,
			31'd9999, 31'd10000, 31'd99999, 31'd100000, 31'd999999, 31'd1000000,
			31'd12345678, 31'd999999999, 31'd1000000000, 31'd1234567890,
			31'h4000_0000, 31'h5555_5555, 31'h2AAA_AAAA, 31'h7FFF_FFFF
		};
		foreach (list[i]) send_value(list[i]);
		stop_sending();
		wait_text_drained();
	endtask

	task automatic test_random_values(int src_pct, int snk_pct, int n);
		set_idling(src_pct, snk_pct);
		repeat (n) send_value(random_value());
		stop_sending();
		wait_text_drained();
	endtask

	// sender holds off until the text of every accepted number is out
	task automatic test_sender_pause_drain();
		set_idling(38, 38);
		repeat (6) send_value(random_value());
		stop_sending();
		wait_text_drained();
		repeat (6) send_value(random_value());
		stop_sending();
		wait_text_drained();
	endtask

	always @(negedge clk) begin
		txt_if.ready <= ($urandom_range(0, 99) >= snk_stall_pct);
	end

	always @(posedge clk) begin : check_text
		text_char_t want;
		if (arst_n && txt_if.valid && txt_if.ready) begin
			if (pending_chars.size() == 0) begin
				$error("char_byte: no character expected, got 0x%02h", txt_if.char_byte);
				fail_cnt = fail_cnt + 1;
			end else begin
				want = pending_chars.pop_front();
				if (txt_if.char_byte !== want.ch) begin
					$error("char_byte: expected 0x%02h, got 0x%02h", want.ch, txt_if.char_byte);
					fail_cnt = fail_cnt + 1;
				end
				if (txt_if.last_char !== want.is_last) begin
					$error("last_char: expected %0b, got %0b", want.is_last, txt_if.last_char);
					fail_cnt = fail_cnt + 1;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((num_if.valid && num_if.ready) || (txt_if.valid && txt_if.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		num_if.valid = 1'b0;
		num_if.value = '0;
		txt_if.ready = 1'b0;
		arst_n       = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		set_idling(0, 0);
		test_digit_boundaries();
		test_random_values(0, 0, 70);
		test_random_values(68, 0, 70);
		test_random_values(0, 68, 70);
		test_random_values(38, 38, 70);
		test_sender_pause_drain();

		wait_text_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_cnt == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
